@@ rtl/core/aeu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aeu_pkg
// Shared constants and types of the absolute encoder unwrap checker.
// ---------------------------------------------------------------------------
package aeu_pkg;

   // fixed field widths
   localparam int STAMP_BITS  = 64;
   localparam int RAW_BITS    = 16;
   localparam int LIMIT_BITS  = 32;
   localparam int TOTAL_BITS  = 64;
   localparam int STATUS_BITS = 3;

   // result status codes
   localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_STALE     = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_READ_FAIL = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_JUMP      = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 3'd4;

   // control register indexes
   localparam int CSR_ADDR_BITS = 2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CENTER   = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MAX_JUMP = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TIMEOUT  = 2'd2;

   localparam logic [LIMIT_BITS-1:0] TIMEOUT_RESET = 32'd100000;
   localparam int                    JUMP_RESET    = 256;

   // decision for one reading, drives the state update
   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic                   mark_seen;
      logic                   seed;
      logic                   advance_total;
      logic                   bump_comm;
      logic                   bump_jump;
   } aeu_verdict_type;

endpackage
`default_nettype wire

@@ rtl/core/aeu_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aeu_eval
// Checks one reading against the tracked state and decides how it updates.
// ---------------------------------------------------------------------------
module aeu_eval #(
   parameter int COUNT_BITS = 12
) (
   input  wire logic [aeu_pkg::STAMP_BITS-1:0] stamp_us,
   input  wire logic                           read_ok,
   input  wire logic [aeu_pkg::RAW_BITS-1:0]   raw_value,
   input  wire logic                           seen,
   input  wire logic [aeu_pkg::STAMP_BITS-1:0] last_seen_stamp,
   input  wire logic                           seeded,
   input  wire logic [COUNT_BITS-1:0]          prev_count,
   input  wire logic [aeu_pkg::TOTAL_BITS-1:0] running_total,
   input  wire logic [COUNT_BITS-2:0]          max_jump,
   output aeu_pkg::aeu_verdict_type            verdict,
   output logic [aeu_pkg::TOTAL_BITS-1:0]      total_sum
);

   localparam logic [aeu_pkg::RAW_BITS-1:0] RawMax =
      aeu_pkg::RAW_BITS'((1 << COUNT_BITS) - 1);

   logic                  stale;
   logic                  bad_read;
   logic [COUNT_BITS-1:0] step;
   logic [COUNT_BITS-1:0] step_mag;
   logic                  jump_big;
   logic                  overflow;

   // wrapped step is the modular difference taken as signed
   assign stale    = seen && (stamp_us <= last_seen_stamp);
   assign bad_read = !read_ok || (raw_value > RawMax);
   assign step     = raw_value[COUNT_BITS-1:0] - prev_count;
   assign step_mag = step[COUNT_BITS-1] ? (~step + 1'b1) : step;
   assign jump_big = step_mag > {1'b0, max_jump};

   // signed add with overflow on matching input signs
   assign total_sum = running_total +
                      {{(aeu_pkg::TOTAL_BITS-COUNT_BITS){step[COUNT_BITS-1]}}, step};
   assign overflow  = (running_total[aeu_pkg::TOTAL_BITS-1] == step[COUNT_BITS-1]) &&
                      (total_sum[aeu_pkg::TOTAL_BITS-1] !=
                       running_total[aeu_pkg::TOTAL_BITS-1]);

   // priority of rejections
   always_comb begin
      verdict = '0;
      verdict.status = aeu_pkg::ST_OK;
      if (stale) begin
         verdict.status    = aeu_pkg::ST_STALE;
         verdict.bump_comm = 1'b1;
      end else begin
         verdict.mark_seen = 1'b1;
         if (bad_read) begin
            verdict.status    = aeu_pkg::ST_READ_FAIL;
            verdict.bump_comm = 1'b1;
         end else if (!seeded) begin
            verdict.seed = 1'b1;
         end else if (jump_big) begin
            verdict.status    = aeu_pkg::ST_JUMP;
            verdict.bump_jump = 1'b1;
         end else if (overflow) begin
            verdict.status    = aeu_pkg::ST_OVERFLOW;
            verdict.bump_jump = 1'b1;
         end else begin
            verdict.advance_total = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/aeu_report.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aeu_report
// Forms the centre offset and the freshness flag from the updated state.
// ---------------------------------------------------------------------------
module aeu_report #(
   parameter int COUNT_BITS = 12
) (
   input  wire logic [aeu_pkg::STAMP_BITS-1:0] stamp_us,
   input  wire logic [aeu_pkg::LIMIT_BITS-1:0] timeout_override,
   input  wire logic [aeu_pkg::LIMIT_BITS-1:0] fresh_timeout,
   input  wire logic                           seeded,
   input  wire logic [aeu_pkg::STAMP_BITS-1:0] last_good_stamp,
   input  wire logic [COUNT_BITS-1:0]          count,
   input  wire logic [COUNT_BITS-1:0]          center_count,
   output logic [COUNT_BITS-1:0]               offset_from_center,
   output logic                                is_fresh
);

   logic [aeu_pkg::LIMIT_BITS-1:0] limit;
   logic [aeu_pkg::STAMP_BITS-1:0] age;

   // modular difference is already the wrapped signed offset
   assign offset_from_center = count - center_count;

   // zero override selects the configured timeout
   assign limit    = (timeout_override == '0) ? fresh_timeout : timeout_override;
   assign age      = stamp_us - last_good_stamp;
   assign is_fresh = seeded && (stamp_us >= last_good_stamp) &&
                     (age <= {{(aeu_pkg::STAMP_BITS-aeu_pkg::LIMIT_BITS){1'b0}}, limit});

endmodule
`default_nettype wire

@@ rtl/core/absolute_encoder_unwrap_checker_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// absolute_encoder_unwrap_checker_unit
// Multi-turn unwrap and plausibility check for timestamped encoder readings.
// ---------------------------------------------------------------------------
// One beat in gives one beat out. A beat is taken into an input register,
// then checked and folded into the tracked state once the output register is
// free, and its result is held in the output register until taken; a new
// beat is accepted every cycle while the result side keeps up. The per-beat
// path is the 64-bit step add with its overflow test and the 64-bit timestamp
// compares. No clearing pass follows reset; the block is ready as soon as
// reset drops.
// ---------------------------------------------------------------------------
module absolute_encoder_unwrap_checker_unit #(
   parameter int COUNT_BITS = 12,
   parameter int TALLY_BITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // control registers
   input  wire logic                              csr_we,
   input  wire logic [aeu_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [aeu_pkg::LIMIT_BITS-1:0]    csr_wdata,
   // reading beats
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // stamp_us[63:0], raw_value[79:64], timeout_override[111:80]
   input  wire logic [111:0]                      req_tdata,
   // read_ok
   input  wire logic                              req_tuser,
   // result beats
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // stamp_echo, last_count, offset_from_center, total_count, comm_errors,
   // jump_errors, is_fresh, zero fill
   output logic [((2*aeu_pkg::STAMP_BITS + 2*COUNT_BITS + 2*TALLY_BITS + 1 + 7) / 8) * 8 - 1:0]
                                                  rsp_tdata,
   // sample_valid, status
   output logic [aeu_pkg::STATUS_BITS:0]          rsp_tuser
);

   localparam int RspBits = 2*aeu_pkg::STAMP_BITS + 2*COUNT_BITS + 2*TALLY_BITS + 1;
   localparam int RspW    = ((RspBits + 7) / 8) * 8;
   localparam int SB      = aeu_pkg::STAMP_BITS;
   localparam int RB      = aeu_pkg::RAW_BITS;
   localparam int LB      = aeu_pkg::LIMIT_BITS;
   localparam int TB      = aeu_pkg::TOTAL_BITS;

   // configuration
   logic [COUNT_BITS-1:0] center_ff;
   logic [COUNT_BITS-2:0] max_jump_ff;
   logic [LB-1:0]         timeout_ff;

   // input stage
   logic          in_valid_ff, in_valid_in;
   logic [SB-1:0] in_stamp_ff;
   logic          in_ok_ff;
   logic [RB-1:0] in_raw_ff;
   logic [LB-1:0] in_limit_ff;

   // tracked state
   logic                  seen_ff, seen_in;
   logic [SB-1:0]         last_seen_ff, last_seen_in;
   logic [SB-1:0]         last_good_ff, last_good_in;
   logic [COUNT_BITS-1:0] prev_count_ff, prev_count_in;
   logic [TB-1:0]         total_ff, total_in;
   logic                  seeded_ff, seeded_in;
   logic [TALLY_BITS-1:0] comm_tally_ff, comm_tally_in;
   logic [TALLY_BITS-1:0] jump_tally_ff, jump_tally_in;

   // result stage
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [aeu_pkg::STATUS_BITS-1:0] out_status_ff;
   logic [SB-1:0]                   out_stamp_ff;
   logic [COUNT_BITS-1:0]           out_count_ff;
   logic [COUNT_BITS-1:0]           out_offset_ff;
   logic [TB-1:0]                   out_total_ff;
   logic [TALLY_BITS-1:0]           out_comm_ff;
   logic [TALLY_BITS-1:0]           out_jump_ff;
   logic                            out_fresh_ff;

   logic                     req_fire;
   logic                     out_free;
   logic                     step_fire;
   aeu_pkg::aeu_verdict_type verdict;
   logic [TB-1:0]            total_sum;
   logic [COUNT_BITS-1:0]    offset;
   logic                     fresh;

   // handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step_fire  = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire || (in_valid_ff && !step_fire);
   assign rsp_valid_in = step_fire || (rsp_valid_ff && !rsp_tready);

   // check of the held beat
   aeu_eval #(
      .COUNT_BITS(COUNT_BITS)
   ) u_eval (
      .stamp_us       (in_stamp_ff),
      .read_ok        (in_ok_ff),
      .raw_value      (in_raw_ff),
      .seen           (seen_ff),
      .last_seen_stamp(last_seen_ff),
      .seeded         (seeded_ff),
      .prev_count     (prev_count_ff),
      .running_total  (total_ff),
      .max_jump       (max_jump_ff),
      .verdict        (verdict),
      .total_sum      (total_sum)
   );

   // next tracked state
   always_comb begin
      seen_in       = seen_ff || verdict.mark_seen;
      last_seen_in  = verdict.mark_seen ? in_stamp_ff : last_seen_ff;
      seeded_in     = seeded_ff;
      prev_count_in = prev_count_ff;
      total_in      = total_ff;
      last_good_in  = last_good_ff;
      if (verdict.seed) begin
         seeded_in     = 1'b1;
         prev_count_in = in_raw_ff[COUNT_BITS-1:0];
         total_in      = {{(TB-COUNT_BITS){1'b0}}, in_raw_ff[COUNT_BITS-1:0]};
         last_good_in  = in_stamp_ff;
      end else if (verdict.advance_total) begin
         prev_count_in = in_raw_ff[COUNT_BITS-1:0];
         total_in      = total_sum;
         last_good_in  = in_stamp_ff;
      end
      comm_tally_in = comm_tally_ff;
      if (verdict.bump_comm && (comm_tally_ff != '1)) begin
         comm_tally_in = comm_tally_ff + 1'b1;
      end
      jump_tally_in = jump_tally_ff;
      if (verdict.bump_jump && (jump_tally_ff != '1)) begin
         jump_tally_in = jump_tally_ff + 1'b1;
      end
   end

   // offset and freshness after the update
   aeu_report #(
      .COUNT_BITS(COUNT_BITS)
   ) u_report (
      .stamp_us          (in_stamp_ff),
      .timeout_override  (in_limit_ff),
      .fresh_timeout     (timeout_ff),
      .seeded            (seeded_in),
      .last_good_stamp   (last_good_in),
      .count             (prev_count_in),
      .center_count      (center_ff),
      .offset_from_center(offset),
      .is_fresh          (fresh)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff   <= '0;
         max_jump_ff <= (COUNT_BITS-1)'(aeu_pkg::JUMP_RESET);
         timeout_ff  <= aeu_pkg::TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            aeu_pkg::CSR_CENTER:   center_ff   <= csr_wdata[COUNT_BITS-1:0];
            aeu_pkg::CSR_MAX_JUMP: max_jump_ff <= csr_wdata[COUNT_BITS-2:0];
            aeu_pkg::CSR_TIMEOUT:  timeout_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // valid flags and tracked state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         seen_ff       <= 1'b0;
         last_seen_ff  <= '0;
         last_good_ff  <= '0;
         prev_count_ff <= '0;
         total_ff      <= '0;
         seeded_ff     <= 1'b0;
         comm_tally_ff <= '0;
         jump_tally_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_fire) begin
            seen_ff       <= seen_in;
            last_seen_ff  <= last_seen_in;
            last_good_ff  <= last_good_in;
            prev_count_ff <= prev_count_in;
            total_ff      <= total_in;
            seeded_ff     <= seeded_in;
            comm_tally_ff <= comm_tally_in;
            jump_tally_ff <= jump_tally_in;
         end
      end
   end

   // input beat capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_stamp_ff <= req_tdata[SB-1:0];
         in_raw_ff   <= req_tdata[SB+RB-1:SB];
         in_limit_ff <= req_tdata[SB+RB+LB-1:SB+RB];
         in_ok_ff    <= req_tuser;
      end
   end

   // result beat capture
   always_ff @(posedge clock) begin
      if (step_fire) begin
         out_status_ff <= verdict.status;
         out_stamp_ff  <= in_stamp_ff;
         out_count_ff  <= prev_count_in;
         out_offset_ff <= offset;
         out_total_ff  <= total_in;
         out_comm_ff   <= comm_tally_in;
         out_jump_ff   <= jump_tally_in;
         out_fresh_ff  <= fresh;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {out_status_ff, out_status_ff == aeu_pkg::ST_OK};
   assign rsp_tdata  = {{(RspW-RspBits){1'b0}}, out_fresh_ff, out_jump_ff, out_comm_ff,
                        out_total_ff, out_offset_ff, out_count_ff, out_stamp_ff};

   // an accepted reading is always fresh at its own stamp
   a_good_is_fresh: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (out_status_ff == aeu_pkg::ST_OK) |-> out_fresh_ff)
      else $error("accepted reading reported stale");

   // tallies never move backward
   a_tally_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (comm_tally_ff >= $past(comm_tally_ff)) &&
               (jump_tally_ff >= $past(jump_tally_ff)))
      else $error("error tally decreased");

   // total stays zero until the first good reading
   a_unseeded_total: assert property (@(posedge clock) disable iff (reset)
      !seeded_ff |-> (total_ff == '0) && (prev_count_ff == '0))
      else $error("total moved before seeding");

   // a held beat is not overwritten while the result side stalls
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_stamp_ff))
      else $error("input beat lost under stall");

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Stream-level check of the absolute encoder unwrap checker.
// ---------------------------------------------------------------------------
// Readings are queued by the stimulus process and sent by a clocked driver.
// Each accepted reading runs through a local tracker of the unwrap state,
// which pushes the expected result. A clocked receiver compares every result
// beat with the oldest expectation. Register settings change between phases
// once the block has drained. Both sides idle at random; the receiver also
// holds off once for a long stretch so that the block backs up.
// ---------------------------------------------------------------------------
module testbench;

   localparam int COUNT_SPAN = 4096;
   localparam int COUNT_HALF = 2048;
   localparam int RSP_BITS   = ((2*aeu_pkg::STAMP_BITS + 2*12 + 2*32 + 1 + 7) / 8) * 8;

   typedef struct {
      logic [63:0] stamp_us;
      logic        read_ok;
      logic [15:0] raw_value;
      logic [31:0] timeout_override;
   } reading_type;

   typedef struct {
      logic                            sample_valid;
      logic [aeu_pkg::STATUS_BITS-1:0] status;
      logic [63:0]                     stamp_echo;
      logic [11:0]                     last_count;
      logic [11:0]                     offset_from_center;
      logic [63:0]                     total_count;
      logic [31:0]                     comm_errors;
      logic [31:0]                     jump_errors;
      logic                            is_fresh;
   } unwrap_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              csr_we    = 1'b0;
   logic [aeu_pkg::CSR_ADDR_BITS-1:0] csr_addr  = aeu_pkg::CSR_CENTER;
   logic [aeu_pkg::LIMIT_BITS-1:0]    csr_wdata = '0;

   logic          req_tvalid = 1'b0;
   logic          req_tready;
   // stamp_us, raw_value, timeout_override
   logic [111:0]  req_tdata  = '0;
   // read_ok
   logic          req_tuser  = 1'b0;

   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   // stamp_echo, last_count, offset_from_center, total_count, comm_errors,
   // jump_errors, is_fresh, zero fill
   logic [RSP_BITS-1:0]           rsp_tdata;
   // sample_valid, status
   logic [aeu_pkg::STATUS_BITS:0] rsp_tuser;

   // stimulus and expectations
   reading_type       reading_q[$];
   unwrap_result_type unwrap_q[$];
   reading_type       offered;
   int                error_count   = 0;
   int                results_taken = 0;
   int                hold_left     = 0;
   bit                hold_done     = 1'b0;
   bit                calm          = 1'b0;

   // tracker copy of registers and state
   logic [11:0]        center_cfg  = 12'd0;
   logic [10:0]        jump_cfg    = 11'(aeu_pkg::JUMP_RESET);
   logic [31:0]        timeout_cfg = aeu_pkg::TIMEOUT_RESET;
   bit                 seen        = 1'b0;
   logic [63:0]        last_seen   = '0;
   logic [63:0]        last_good   = '0;
   logic [11:0]        held_count  = '0;
   logic signed [63:0] run_total   = '0;
   bit                 seeded      = 1'b0;
   logic [31:0]        comm_tally  = '0;
   logic [31:0]        jump_tally  = '0;

   // generator state
   logic [63:0] stamp_cursor = '0;
   logic [11:0] gen_count    = '0;

   absolute_encoder_unwrap_checker_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // signed step between two counts, folded into half a turn
   function automatic int wrapped_step(logic [11:0] now, logic [11:0] prior);
      int d;
      d = int'(now) - int'(prior);
      if (d >= COUNT_HALF) begin
         d -= COUNT_SPAN;
      end else if (d < -COUNT_HALF) begin
         d += COUNT_SPAN;
      end
      return d;
   endfunction

   function automatic logic [31:0] bumped(logic [31:0] tally);
      return (tally == '1) ? tally : tally + 32'd1;
   endfunction

   // fold one reading into the tracked state and form its result
   task automatic unwrap_reading(input reading_type r, output unwrap_result_type e);
      logic [aeu_pkg::STATUS_BITS-1:0] st;
      int                              step;
      int                              mag;
      logic signed [64:0]              sum;
      logic [63:0]                     limit;
      st = aeu_pkg::ST_OK;
      if (seen && r.stamp_us <= last_seen) begin
         st = aeu_pkg::ST_STALE;
         comm_tally = bumped(comm_tally);
      end else begin
         last_seen = r.stamp_us;
         seen = 1'b1;
         if (!r.read_ok || r.raw_value > 16'h0FFF) begin
            st = aeu_pkg::ST_READ_FAIL;
            comm_tally = bumped(comm_tally);
         end else if (!seeded) begin
            held_count = r.raw_value[11:0];
            run_total = {52'd0, r.raw_value[11:0]};
            last_good = r.stamp_us;
            seeded = 1'b1;
         end else begin
            step = wrapped_step(r.raw_value[11:0], held_count);
            mag = (step < 0) ? -step : step;
            sum = $signed({run_total[63], run_total}) + 65'(step);
            if (mag > int'(jump_cfg)) begin
               st = aeu_pkg::ST_JUMP;
               jump_tally = bumped(jump_tally);
            end else if (sum[64] != sum[63]) begin
               st = aeu_pkg::ST_OVERFLOW;
               jump_tally = bumped(jump_tally);
            end else begin
               held_count = r.raw_value[11:0];
               run_total = sum[63:0];
               last_good = r.stamp_us;
            end
         end
      end
      limit = {32'd0, (r.timeout_override == '0) ? timeout_cfg : r.timeout_override};
      e.sample_valid       = (st == aeu_pkg::ST_OK);
      e.status             = st;
      e.stamp_echo         = r.stamp_us;
      e.last_count         = held_count;
      e.offset_from_center = 12'(wrapped_step(held_count, center_cfg));
      e.total_count        = run_total;
      e.comm_errors        = comm_tally;
      e.jump_errors        = jump_tally;
      e.is_fresh           = seeded && r.stamp_us >= last_good &&
                             (r.stamp_us - last_good) <= limit;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // driver: offer queued readings, track each accepted beat
   always @(posedge clock) begin : drive_readings
      unwrap_result_type want;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            unwrap_reading(offered, want);
            unwrap_q.push_back(want);
         end
         if (reading_q.size() > 0 && (calm || $urandom_range(0, 99) >= 15)) begin
            offered = reading_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {offered.timeout_override, offered.raw_value, offered.stamp_us};
            req_tuser  <= offered.read_ok;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: compare result beats, random stalls plus one long hold-off
   always @(posedge clock) begin : watch_results
      unwrap_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (unwrap_q.size() == 0) begin
               $display("%0t mismatch beat: expected none, actual %h / %h",
                        $time, rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               want = unwrap_q.pop_front();
               check_field("sample_valid", want.sample_valid, rsp_tuser[0]);
               check_field("status", want.status, rsp_tuser[aeu_pkg::STATUS_BITS:1]);
               check_field("stamp_echo", want.stamp_echo, rsp_tdata[63:0]);
               check_field("last_count", want.last_count, rsp_tdata[75:64]);
               check_field("offset_from_center", want.offset_from_center,
                           rsp_tdata[87:76]);
               check_field("total_count", want.total_count, rsp_tdata[151:88]);
               check_field("comm_errors", want.comm_errors, rsp_tdata[183:152]);
               check_field("jump_errors", want.jump_errors, rsp_tdata[215:184]);
               check_field("is_fresh", want.is_fresh, rsp_tdata[216]);
            end
            results_taken++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (results_taken == 150 && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 80;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || $urandom_range(0, 99) >= 15;
         end
      end
   end

   task automatic add_reading(input logic [63:0] stamp, input logic ok,
                              input logic [15:0] raw, input logic [31:0] ovr);
      reading_type r;
      r.stamp_us = stamp;
      r.read_ok = ok;
      r.raw_value = raw;
      r.timeout_override = ovr;
      reading_q.push_back(r);
      if (stamp > stamp_cursor) begin
         stamp_cursor = stamp;
      end
   endtask

   // wait until the block holds nothing and every result is in
   task automatic drain;
      do @(negedge clock);
      while (reading_q.size() != 0 || req_tvalid || unwrap_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [aeu_pkg::CSR_ADDR_BITS-1:0] idx,
                            input logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         aeu_pkg::CSR_CENTER:   center_cfg = value[11:0];
         aeu_pkg::CSR_MAX_JUMP: jump_cfg = value[10:0];
         aeu_pkg::CSR_TIMEOUT:  timeout_cfg = value;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] next_advance();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 64'($urandom_range(1, 4));
      if (pick < 90) return 64'($urandom_range(1, 200000));
      if (pick < 98) return 64'($urandom) + 64'd1;
      return {20'd0, 12'($urandom_range(0, 4095)), 32'($urandom)} + 64'd1;
   endfunction

   function automatic logic [31:0] pick_override();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 32'd0;
      if (pick < 75) return 32'($urandom_range(1, 300));
      return $urandom;
   endfunction

   // mostly well-formed motion within the jump limit, plus jumps, stale stamps and failed or out-of-range reads
   task automatic add_random_readings(input int n);
      int          kind;
      int          lim;
      int          step;
      logic [63:0] stamp;
      logic [15:0] raw;
      logic        ok;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(0, 99);
         ok = 1'b1;
         stamp = stamp_cursor + next_advance();
         if (kind < 70) begin
            lim = int'(jump_cfg);
            step = (lim == 0) ? 0 : int'($urandom_range(0, 2 * lim)) - lim;
            gen_count = 12'(int'(gen_count) + step);
            raw = {4'd0, gen_count};
         end else if (kind < 78) begin
            raw = 16'($urandom_range(0, 4095));
         end else if (kind < 84) begin
            stamp = stamp_cursor - 64'($urandom_range(0, 65535));
            raw = {4'd0, gen_count};
         end else if (kind < 90) begin
            ok = 1'b0;
            raw = 16'($urandom_range(0, 65535));
         end else if (kind < 95) begin
            raw = 16'($urandom_range(4096, 65535));
         end else begin
            ok = 1'($urandom_range(0, 1));
            raw = 16'($urandom_range(0, 65535));
         end
         add_reading(stamp, ok, raw, pick_override());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, seeding, wrap, limits and freshness edges
      add_reading(64'd0, 1'b0, 16'd100, 32'd0);
      add_reading(64'd0, 1'b1, 16'd100, 32'd0);
      add_reading(64'd5, 1'b1, 16'h1000, 32'd0);
      add_reading(64'd6, 1'b1, 16'hFFFF, 32'd0);
      add_reading(64'd10, 1'b1, 16'd4095, 32'd0);
      add_reading(64'd20, 1'b1, 16'd0, 32'd0);
      add_reading(64'd30, 1'b1, 16'd4095, 32'd0);
      add_reading(64'd40, 1'b1, 16'd256, 32'd0);
      add_reading(64'd50, 1'b1, 16'd255, 32'd0);
      add_reading(64'd45, 1'b1, 16'd255, 32'd0);
      add_reading(64'd50, 1'b1, 16'd255, 32'd0);
      add_reading(64'd100050, 1'b0, 16'd0, 32'd0);
      add_reading(64'd100051, 1'b0, 16'd0, 32'd0);
      add_reading(64'd100060, 1'b1, 16'd2303, 32'd0);
      add_reading(64'd100070, 1'b0, 16'd4095, 32'd1);
      add_reading(64'd100080, 1'b0, 16'd0, 32'hFFFF_FFFF);
      add_reading(64'd100090, 1'b1, 16'd500, 32'hAAAA_5555);
      add_reading(64'd100100, 1'b1, 16'd4095, 32'd0);
      add_reading(64'd100110, 1'b1, 16'd0, 32'h5555_AAAA);
      add_reading(64'd100120, 1'b1, 16'd300, 32'd0);
      gen_count = 12'd300;
      drain();

      // widest jump window, shortest nonzero timeout, centre at the top
      write_reg(aeu_pkg::CSR_CENTER, 32'd4095);
      write_reg(aeu_pkg::CSR_MAX_JUMP, 32'd2047);
      write_reg(aeu_pkg::CSR_TIMEOUT, 32'd1);
      add_random_readings(100);
      drain();

      // no random idling on either side, narrow window, longest timeout
      calm = 1'b1;
      write_reg(aeu_pkg::CSR_CENTER, 32'd2048);
      write_reg(aeu_pkg::CSR_MAX_JUMP, 32'd1);
      write_reg(aeu_pkg::CSR_TIMEOUT, 32'hFFFF_FFFF);
      add_random_readings(100);
      drain();
      calm = 1'b0;

      // zero window accepts only an unchanged count
      write_reg(aeu_pkg::CSR_CENTER, 32'($urandom_range(0, 4095)));
      write_reg(aeu_pkg::CSR_MAX_JUMP, 32'd0);
      write_reg(aeu_pkg::CSR_TIMEOUT, 32'd50);
      add_random_readings(60);
      drain();

      // back to default limits, split by a full pause of the sender
      write_reg(aeu_pkg::CSR_CENTER, 32'($urandom_range(0, 4095)));
      write_reg(aeu_pkg::CSR_MAX_JUMP, 32'd256);
      write_reg(aeu_pkg::CSR_TIMEOUT, 32'd100000);
      add_random_readings(70);
      drain();
      add_random_readings(70);

      // largest timestamp, then nothing can advance past it
      add_reading(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, {4'd0, gen_count}, 32'd0);
      add_reading(64'h8000_0000_0000_0000, 1'b1, {4'd0, gen_count}, 32'd0);
      add_reading(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 16'hFFFF, 32'hFFFF_FFFF);
      drain();
      repeat (8) @(posedge clock);

      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
